### sv/lgt_pkg.sv
// Shared types, codes and constants for the leg target tracker.
`timescale 1ns / 1ps
`default_nettype none

package lgt_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_SCAN    = 2'd0;
    localparam logic [1:0] OP_ENABLE  = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W          = 3;
    localparam int         CFG_DATA_W         = 16;
    localparam logic [2:0] CFG_ACQUIRE_FRAMES = 3'd0;
    localparam logic [2:0] CFG_LOST_FRAMES    = 3'd1;
    localparam logic [2:0] CFG_GATE_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_FRONT_MIN_X    = 3'd3;
    localparam logic [2:0] CFG_FRONT_MAX_X    = 3'd4;
    localparam logic [2:0] CFG_FRONT_MIN_Y    = 3'd5;
    localparam logic [2:0] CFG_FRONT_MAX_Y    = 3'd6;

    // Configuration reset values.
    localparam logic [4:0]         RST_ACQUIRE_FRAMES = 5'd20;
    localparam logic [4:0]         RST_LOST_FRAMES    = 5'd20;
    localparam logic [14:0]        RST_GATE_RADIUS    = 15'd1352;
    localparam logic signed [15:0] RST_FRONT_MIN_X    = 16'sd1024;
    localparam logic signed [15:0] RST_FRONT_MAX_X    = 16'sd6144;
    localparam logic signed [15:0] RST_FRONT_MIN_Y    = -16'sd2048;
    localparam logic signed [15:0] RST_FRONT_MAX_Y    = 16'sd2048;

    // Saturation limit of the scan counters.
    localparam logic [5:0] COUNT_MAX = 6'd63;

    // Filter step modes.
    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_SEED = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // Filter coefficients, signed Q2.28. Feedback terms are stored negated.
    localparam int                 FRAC_BITS = 28;
    localparam int                 ACC_W     = 48;
    localparam logic signed [29:0] COEF_B0     = 30'sd4858395;
    localparam logic signed [29:0] COEF_B1     = 30'sd14575186;
    localparam logic signed [29:0] COEF_NEG_A1 = 30'sd472457645;
    localparam logic signed [29:0] COEF_NEG_A2 = -30'sd317530492;
    localparam logic signed [29:0] COEF_NEG_A3 = 30'sd74641141;
    // Partial sums for a history filled with one point: 2*B1+B0 and -(A2+A3).
    localparam logic signed [29:0] COEF_SEED_IN  = 30'sd34008767;
    localparam logic signed [29:0] COEF_SEED_OUT = -30'sd242889351;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]         operation;
        logic               candidate_valid;
        logic signed [15:0] candidate_x;
        logic signed [15:0] candidate_y;
        logic               scan_end;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic               person_found;
        logic               pose_valid;
        logic signed [15:0] filtered_x;
        logic signed [15:0] filtered_y;
    } t_out_item;

    // Scan result handed from the tracking stage to the filter stage.
    typedef struct packed {
        logic               found;
        logic               matched;
        logic [1:0]         mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_stage;

    // Filter step control.
    typedef struct packed {
        logic       step;
        logic [1:0] mode;
    } t_filt_ctl;

endpackage

`default_nettype wire

### sv/lgt_filter.sv
// Third-order low-pass IIR on one axis, one step per scan.
`timescale 1ns / 1ps
`default_nettype none

module lgt_filter
    import lgt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_filt_ctl          i_ctl,
    input  wire logic signed [15:0] i_point,
    output logic signed [15:0]      o_value
);

    typedef logic signed [ACC_W-1:0] t_acc;

    // Constant multiply, widened to the accumulator.
    function automatic t_acc mulc(input logic signed [16:0] v, input logic signed [29:0] c);
        t_acc ve;
        t_acc ce;
        ve = t_acc'(v);
        ce = t_acc'(c);
        return ve * ce;
    endfunction

    logic signed [15:0] r_ih0, r_ih1, r_oh0, r_oh1;
    t_acc               r_bpart, r_apart;
    t_acc               n_bpart, n_apart;
    t_acc               acc;
    logic signed [19:0] rounded;
    logic signed [15:0] y_run;
    logic signed [16:0] pt_ext, in_pair;

    assign pt_ext  = 17'(i_point);
    assign in_pair = 17'(i_point) + 17'(r_ih0);

    // Recursion: only the newest input and output are multiplied here, the
    // older terms were summed when the previous step completed.
    always_comb begin
        acc     = mulc(pt_ext, COEF_B0) + r_bpart + mulc(17'(r_oh0), COEF_NEG_A1) + r_apart;
        acc     = acc + (t_acc'(1) <<< (FRAC_BITS - 1));
        rounded = 20'(acc >>> FRAC_BITS);
        if (rounded > 20'sd32767) begin
            y_run = 16'sd32767;
        end else if (rounded < -20'sd32768) begin
            y_run = -16'sd32768;
        end else begin
            y_run = 16'(rounded);
        end
    end

    // Partial sums for the next step.
    always_comb begin
        if (i_ctl.mode == MODE_SEED) begin
            n_bpart = mulc(pt_ext, COEF_SEED_IN);
            n_apart = mulc(pt_ext, COEF_SEED_OUT);
        end else begin
            n_bpart = mulc(in_pair, COEF_B1) + mulc(17'(r_ih1), COEF_B0);
            n_apart = mulc(17'(r_oh0), COEF_NEG_A2) + mulc(17'(r_oh1), COEF_NEG_A3);
        end
    end

    // Value reported for this step.
    always_comb begin
        case (i_ctl.mode)
            MODE_SEED: o_value = i_point;
            MODE_RUN:  o_value = y_run;
            default:   o_value = r_oh0;
        endcase
    end

    // History update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ih0   <= '0;
            r_ih1   <= '0;
            r_oh0   <= '0;
            r_oh1   <= '0;
            r_bpart <= '0;
            r_apart <= '0;
        end else if (i_ctl.step && (i_ctl.mode == MODE_SEED)) begin
            r_ih0   <= i_point;
            r_ih1   <= i_point;
            r_oh0   <= i_point;
            r_oh1   <= i_point;
            r_bpart <= n_bpart;
            r_apart <= n_apart;
        end else if (i_ctl.step && (i_ctl.mode == MODE_RUN)) begin
            r_ih0   <= i_point;
            r_ih1   <= r_ih0;
            r_oh0   <= y_run;
            r_oh1   <= r_oh0;
            r_bpart <= n_bpart;
            r_apart <= n_apart;
        end
    end

endmodule

`default_nettype wire

### sv/leg_target_tracker_core.sv
// Top level of the leg target tracker: scan tracking stage and output filter.
`timescale 1ns / 1ps
`default_nettype none

// The tracker takes one transaction per clock when not stalled. A result passes
// through an input register, the tracking stage (two 17x17 squarers, the
// nearest-candidate compare and the scan-end decision) and the filter stage,
// whose recursion holds two constant multiplies per axis, to the output register.
// Only the last transaction of a scan that arrives while the block is enabled
// produces a result. There is no clearing pass after reset. Back pressure on
// the output stalls the pipeline one stage at a time, so input is taken as
// long as any stage can move.
module leg_target_tracker_core
    import lgt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    // Configuration registers. The gate radius is kept squared for the compare.
    logic [4:0]         r_acquire_frames, r_lost_frames;
    logic signed [15:0] r_front_min_x, r_front_max_x, r_front_min_y, r_front_max_y;
    logic [29:0]        r_gate_sq;
    logic [29:0]        cfg_gate_sq;

    assign cfg_gate_sq = 30'(i_cfg_data[14:0]) * 30'(i_cfg_data[14:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acquire_frames <= RST_ACQUIRE_FRAMES;
            r_lost_frames    <= RST_LOST_FRAMES;
            r_gate_sq        <= 30'(RST_GATE_RADIUS) * 30'(RST_GATE_RADIUS);
            r_front_min_x    <= RST_FRONT_MIN_X;
            r_front_max_x    <= RST_FRONT_MAX_X;
            r_front_min_y    <= RST_FRONT_MIN_Y;
            r_front_max_y    <= RST_FRONT_MAX_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACQUIRE_FRAMES: r_acquire_frames <= i_cfg_data[4:0];
                CFG_LOST_FRAMES:    r_lost_frames    <= i_cfg_data[4:0];
                CFG_GATE_RADIUS:    r_gate_sq        <= cfg_gate_sq;
                CFG_FRONT_MIN_X:    r_front_min_x    <= i_cfg_data;
                CFG_FRONT_MAX_X:    r_front_max_x    <= i_cfg_data;
                CFG_FRONT_MIN_Y:    r_front_min_y    <= i_cfg_data;
                CFG_FRONT_MAX_Y:    r_front_max_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake.
    logic     r_in_valid, r_b_valid, r_out_valid;
    t_in_item r_in;
    t_stage   r_b;
    t_out_item r_out;
    logic     a_result, a_fire, b_fire, b_ready, out_free;
    t_stage   a_stage;

    assign out_free   = !r_out_valid || i_out_ready;
    assign b_fire     = r_b_valid && out_free;
    assign b_ready    = !r_b_valid || b_fire;
    assign a_fire     = r_in_valid && (!a_result || b_ready);
    assign o_in_ready = !r_in_valid || a_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Tracking state.
    logic               r_enabled, r_found, r_best_seen;
    logic [5:0]         r_front_count, r_miss_count;
    logic signed [15:0] r_last_x, r_last_y, r_best_x, r_best_y;
    logic [32:0]        r_best_d;
    logic               n_enabled, n_found, n_best_seen;
    logic [5:0]         n_front_count, n_miss_count;
    logic signed [15:0] n_last_x, n_last_y, n_best_x, n_best_y;
    logic [32:0]        n_best_d;

    // Candidate distance: to the last pose while tracking, else to the origin.
    logic signed [16:0] dx, dy;
    logic signed [33:0] sq_x, sq_y;
    logic [32:0]        cand_d;
    logic               in_window, take;

    assign dx = 17'(r_in.candidate_x) - (r_found ? 17'(r_last_x) : 17'sd0);
    assign dy = 17'(r_in.candidate_y) - (r_found ? 17'(r_last_y) : 17'sd0);
    assign sq_x   = dx * dx;
    assign sq_y   = dy * dy;
    assign cand_d = {1'b0, sq_x[31:0]} + {1'b0, sq_y[31:0]};
    assign in_window = (r_in.candidate_x > r_front_min_x) && (r_in.candidate_x < r_front_max_x)
                    && (r_in.candidate_y > r_front_min_y) && (r_in.candidate_y < r_front_max_y);
    assign take = r_in.candidate_valid && (r_found || in_window) && (cand_d < r_best_d);

    // Next tracking state and the scan result for the filter stage.
    logic               seen_now;
    logic [32:0]        d_now;
    logic signed [15:0] bx_now, by_now;
    logic [5:0]         fc_inc, miss_inc;
    logic               matched;

    always_comb begin
        n_enabled     = r_enabled;
        n_found       = r_found;
        n_best_seen   = r_best_seen;
        n_front_count = r_front_count;
        n_miss_count  = r_miss_count;
        n_last_x      = r_last_x;
        n_last_y      = r_last_y;
        n_best_x      = r_best_x;
        n_best_y      = r_best_y;
        n_best_d      = r_best_d;
        a_result      = 1'b0;
        a_stage       = '0;
        seen_now      = r_best_seen || take;
        d_now         = take ? cand_d : r_best_d;
        bx_now        = take ? r_in.candidate_x : r_best_x;
        by_now        = take ? r_in.candidate_y : r_best_y;
        fc_inc        = (seen_now && (r_front_count < COUNT_MAX)) ? r_front_count + 6'd1
                                                                  : r_front_count;
        miss_inc      = (r_miss_count < COUNT_MAX) ? r_miss_count + 6'd1 : r_miss_count;
        matched       = seen_now && (d_now < {3'b000, r_gate_sq});

        case (r_in.operation)
            OP_ENABLE: begin
                if (!r_enabled) begin
                    n_enabled   = 1'b1;
                    n_found     = 1'b1;
                    n_best_seen = 1'b0;
                    n_best_d    = '1;
                end
            end
            OP_DISABLE: begin
                n_enabled     = 1'b0;
                n_found       = 1'b0;
                n_front_count = '0;
                n_best_seen   = 1'b0;
                n_best_d      = '1;
            end
            OP_SCAN: begin
                if (r_enabled && !r_in.scan_end) begin
                    n_best_seen = seen_now;
                    n_best_d    = d_now;
                    n_best_x    = bx_now;
                    n_best_y    = by_now;
                end else if (r_enabled) begin
                    a_result    = 1'b1;
                    n_best_seen = 1'b0;
                    n_best_d    = '1;
                    if (!r_found) begin
                        // Acquisition: count scans with a front candidate.
                        n_front_count = fc_inc;
                        if (seen_now && (fc_inc > {1'b0, r_acquire_frames})) begin
                            n_found      = 1'b1;
                            n_miss_count = '0;
                            n_last_x     = bx_now;
                            n_last_y     = by_now;
                            a_stage.mode = MODE_SEED;
                        end else begin
                            a_stage.mode = MODE_HOLD;
                        end
                    end else begin
                        // Tracking: gate the nearest candidate, count misses.
                        a_stage.mode = MODE_RUN;
                        if (matched) begin
                            n_last_x     = bx_now;
                            n_last_y     = by_now;
                            n_miss_count = '0;
                        end else begin
                            n_miss_count = miss_inc;
                            if (miss_inc > {1'b0, r_lost_frames}) begin
                                n_found       = 1'b0;
                                n_front_count = '0;
                            end
                        end
                    end
                    a_stage.found   = n_found;
                    a_stage.matched = r_found && matched;
                    a_stage.pos_x   = n_last_x;
                    a_stage.pos_y   = n_last_y;
                end
            end
            default: ;
        endcase
    end

    // Tracking state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_found       <= 1'b0;
            r_best_seen   <= 1'b0;
            r_best_d      <= '1;
            r_front_count <= '0;
            r_miss_count  <= '0;
            r_last_x      <= '0;
            r_last_y      <= '0;
        end else if (a_fire) begin
            r_enabled     <= n_enabled;
            r_found       <= n_found;
            r_best_seen   <= n_best_seen;
            r_best_d      <= n_best_d;
            r_front_count <= n_front_count;
            r_miss_count  <= n_miss_count;
            r_last_x      <= n_last_x;
            r_last_y      <= n_last_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_best_x <= n_best_x;
            r_best_y <= n_best_y;
        end
    end

    // Filter stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= a_fire && a_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && a_fire && a_result) begin
            r_b <= a_stage;
        end
    end

    // Filters on both axes.
    t_filt_ctl          filt_ctl;
    logic signed [15:0] filt_x, filt_y;

    assign filt_ctl.step = b_fire;
    assign filt_ctl.mode = r_b.mode;

    lgt_filter u_filter_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (filt_ctl),
        .i_point (r_b.pos_x),
        .o_value (filt_x)
    );

    lgt_filter u_filter_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (filt_ctl),
        .i_point (r_b.pos_y),
        .o_value (filt_y)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= b_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_out.person_found <= r_b.found;
            r_out.pose_valid   <= r_b.matched;
            r_out.filtered_x   <= filt_x;
            r_out.filtered_y   <= filt_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A track is only held while the block is enabled.
    a_found_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_enabled)
        else $error("track held while disabled");

    // A matched scan never reports a lost track.
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.pose_valid || o_out_data.person_found))
        else $error("match reported without a track");

    // An acquisition scan reports the track found and no match.
    a_seed_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && a_result && (a_stage.mode == MODE_SEED))
            |-> (a_stage.found && !a_stage.matched))
        else $error("acquisition scan with bad flags");

    // A scan result leaves the tracking stage only when the filter stage takes it.
    a_stage_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && a_result) |=> r_b_valid)
        else $error("scan result dropped between stages");

endmodule

`default_nettype wire
